// File: design/kmeans_1d_three_clusters_assert.svh
// Assertion macros for the one-dimensional k-means block.
`ifndef KMEANS_1D_THREE_CLUSTERS_ASSERT_SVH
`define KMEANS_1D_THREE_CLUSTERS_ASSERT_SVH
`ifndef SYNTH
`define KM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/km1d_pkg.sv
`timescale 1ns / 1ps
package km1d_pkg;
    localparam int unsigned NumClusters  = 3;
    localparam logic [3:0]  DefaultPasses = 4'd10;
    localparam logic [1:0]  ClusterZero   = 2'd0;
    localparam logic [1:0]  ClusterOne    = 2'd1;
    localparam logic [1:0]  ClusterTwo    = 2'd2;
endpackage

// File: design/km1d_ram.sv
`timescale 1ns / 1ps
module km1d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/km1d_div.sv
`timescale 1ns / 1ps
// Restoring divider of a signed sum by an unsigned count, quotient truncated
// toward zero, one quotient bit per cycle.
module km1d_div #(
    parameter int SW = 40,
    parameter int CW = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [SW-1:0] dividend,
    input  logic [CW-1:0]        divisor,
    output logic                 done,
    output logic signed [SW-1:0] quotient
);
    localparam int NW = $clog2(SW + 1);

    logic [SW-1:0] q_reg;
    logic [CW:0]   r_reg;
    logic [CW-1:0] d_reg;
    logic          neg_reg;
    logic [NW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW+1:0] trial;

    assign trial = {r_reg, q_reg[SW-1]} - {2'b00, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(SW);
                neg_reg  <= dividend[SW-1];
                q_reg    <= dividend[SW-1] ? SW'(-dividend) : dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end
            else if (busy_reg)
            begin
                if (!trial[CW+1])
                begin
                    r_reg <= trial[CW:0];
                    q_reg <= {q_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= {r_reg[CW-1:0], q_reg[SW-1]};
                    q_reg <= {q_reg[SW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? SW'(-q_reg) : q_reg;
endmodule

// File: design/km1d_core.sv
`timescale 1ns / 1ps
// Batch sequencer: for three or more samples, ranks them for the start centroids
// and runs the passes; smaller batches go to cluster zero. Then streams out the assignments.
module km1d_core
    import km1d_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_last,
    input  logic [3:0]             passes,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             out_index,
    output logic                   out_last,
    output logic                   busy
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int NW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = SAMPLE_BITS + NW;

    typedef enum logic [3:0] {
        S_LOAD, S_RANK_RD, S_RANK_OUT, S_RANK_IN, S_RANK_END,
        S_PASS_RD, S_PASS_RUN, S_PASS_END, S_DIV, S_EMIT_RD, S_EMIT
    } state_t;

    state_t state_reg;
    logic [NW-1:0] n_reg, i_reg, j_reg, rd_i_reg;
    logic [NW-1:0] rank_reg;
    logic [3:0]    pass_reg;
    logic [1:0]    div_c_reg;
    logic          small_reg;
    logic signed [SAMPLE_BITS-1:0] cand_reg;
    logic signed [SAMPLE_BITS-1:0] cent_reg [NumClusters];
    logic signed [SW-1:0]          sum_reg  [NumClusters];
    logic [NW-1:0]                 cnt_reg  [NumClusters];
    logic                          rd_ok_reg;
    logic [1:0]                    oidx_reg;
    logic                          olast_reg;
    logic                          ovalid_reg;

    logic                   s_we, a_we;
    logic [AW-1:0]          s_waddr, s_raddr, a_raddr, a_waddr;
    logic [SAMPLE_BITS-1:0] s_rdata;
    logic [1:0]             a_rdata, a_wdata;

    km1d_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_samples (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(in_sample),
        .raddr(s_raddr), .rdata(s_rdata));
    km1d_ram #(.WIDTH(2), .DEPTH(MAX_SAMPLES)) u_assign (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata));

    logic signed [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS:0] d0, d1, d2;
    logic [1:0] best;
    logic div_start, div_done;
    logic signed [SW-1:0] div_q;
    logic [NW:0] pos_calc [NumClusters];

    assign x = s_rdata;

    always_comb
    begin
        d0 = (x >= cent_reg[0]) ? (SAMPLE_BITS+1)'(x - cent_reg[0])
                                : (SAMPLE_BITS+1)'(cent_reg[0] - x);
        d1 = (x >= cent_reg[1]) ? (SAMPLE_BITS+1)'(x - cent_reg[1])
                                : (SAMPLE_BITS+1)'(cent_reg[1] - x);
        d2 = (x >= cent_reg[2]) ? (SAMPLE_BITS+1)'(x - cent_reg[2])
                                : (SAMPLE_BITS+1)'(cent_reg[2] - x);
        best = ClusterZero;
        if (d1 < d0)
        begin
            best = ClusterOne;
            if (d2 < d1)
            begin
                best = ClusterTwo;
            end
        end
        else if (d2 < d0)
        begin
            best = ClusterTwo;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NumClusters; c++)
        begin
            pos_calc[c] = (NW+1)'(((n_reg * (c + 1)) >> 2));
            if (pos_calc[c] > (NW+1)'(n_reg - NW'(1)))
            begin
                pos_calc[c] = (NW+1)'(n_reg - NW'(1));
            end
        end
    end

    km1d_div #(.SW(SW), .CW(NW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(sum_reg[div_c_reg]), .divisor(cnt_reg[div_c_reg]),
        .done(div_done), .quotient(div_q));

    assign in_ready = (state_reg == S_LOAD);
    assign s_we     = in_valid && in_ready;
    assign s_waddr  = i_reg[AW-1:0];
    // The candidate is read in S_RANK_RD; the scan over all samples issues
    // its reads from j_reg while rd_i_reg, a registered copy of j_reg, holds the
    // position of the data that has just arrived.
    assign s_raddr  = (state_reg == S_RANK_RD) ? i_reg[AW-1:0] :
                      (state_reg == S_RANK_OUT || state_reg == S_RANK_IN
                       || state_reg == S_RANK_END) ? j_reg[AW-1:0] : rd_i_reg[AW-1:0];
    assign a_raddr  = rd_i_reg[AW-1:0];
    assign a_waddr  = i_reg[AW-1:0];
    assign a_wdata  = small_reg ? ClusterZero : best;
    assign a_we     = (state_reg == S_PASS_RUN) && rd_ok_reg;
    assign div_start = (state_reg == S_PASS_END);
    assign out_valid = ovalid_reg;
    assign out_index = oidx_reg;
    assign out_last  = olast_reg;
    assign busy      = (state_reg != S_LOAD) || ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            i_reg      <= '0;
            ovalid_reg <= 1'b0;
            for (int c = 0; c < NumClusters; c++)
            begin
                cent_reg[c] <= '0;
                sum_reg[c]  <= '0;
                cnt_reg[c]  <= '0;
            end
        end
        else
        begin
            if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (s_we)
                    begin
                        if (in_last || i_reg == NW'(MAX_SAMPLES - 1))
                        begin
                            n_reg     <= i_reg + NW'(1);
                            small_reg <= (i_reg < NW'(2));
                            i_reg     <= '0;
                            j_reg     <= '0;
                            state_reg <= (i_reg < NW'(2)) ? S_PASS_RD : S_RANK_RD;
                            rd_i_reg  <= '0;
                            pass_reg  <= '0;
                        end
                        else
                        begin
                            i_reg <= i_reg + NW'(1);
                        end
                    end
                end
                // Rank of sample i = count of samples less than it, plus
                // equal ones at lower positions; the sample whose rank covers
                // a start position is that order statistic.
                S_RANK_RD:
                begin
                    state_reg <= S_RANK_OUT;
                    rd_i_reg  <= i_reg;
                end
                S_RANK_OUT:
                begin
                    cand_reg  <= s_rdata;
                    rank_reg  <= '0;
                    j_reg     <= '0;
                    state_reg <= S_RANK_IN;
                end
                S_RANK_IN:
                begin
                    j_reg     <= j_reg + NW'(1);
                    rd_i_reg  <= j_reg;
                    if (j_reg != '0)
                    begin
                        if ($signed(s_rdata) < cand_reg ||
                            ($signed(s_rdata) == cand_reg && rd_i_reg < i_reg))
                        begin
                            rank_reg <= rank_reg + NW'(1);
                        end
                    end
                    if (j_reg == n_reg)
                    begin
                        state_reg <= S_RANK_END;
                    end
                end
                S_RANK_END:
                begin
                    for (int c = 0; c < NumClusters; c++)
                    begin
                        if ((NW+1)'(rank_reg) == pos_calc[c])
                        begin
                            cent_reg[c] <= cand_reg;
                        end
                    end
                    j_reg <= '0;
                    if (i_reg == n_reg - NW'(1))
                    begin
                        i_reg     <= '0;
                        rd_i_reg  <= '0;
                        state_reg <= S_PASS_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_RANK_RD;
                    end
                end
                S_PASS_RD:
                begin
                    rd_i_reg  <= NW'(1);
                    i_reg     <= '0;
                    rd_ok_reg <= 1'b1;
                    for (int c = 0; c < NumClusters; c++)
                    begin
                        sum_reg[c] <= '0;
                        cnt_reg[c] <= '0;
                    end
                    state_reg <= S_PASS_RUN;
                end
                S_PASS_RUN:
                begin
                    if (!small_reg)
                    begin
                        sum_reg[best] <= sum_reg[best] + SW'(x);
                        cnt_reg[best] <= cnt_reg[best] + NW'(1);
                    end
                    rd_i_reg <= rd_i_reg + NW'(1);
                    i_reg    <= i_reg + NW'(1);
                    if (i_reg == n_reg - NW'(1))
                    begin
                        if (small_reg)
                        begin
                            state_reg <= S_EMIT_RD;
                            rd_i_reg  <= '0;
                            i_reg     <= '0;
                        end
                        else
                        begin
                            div_c_reg <= '0;
                            state_reg <= S_PASS_END;
                        end
                    end
                end
                S_PASS_END:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (cnt_reg[div_c_reg] != '0)
                        begin
                            cent_reg[div_c_reg] <= SAMPLE_BITS'(div_q);
                        end
                        if (div_c_reg == ClusterTwo)
                        begin
                            rd_i_reg <= '0;
                            if (pass_reg + 4'd1 >= passes)
                            begin
                                i_reg     <= '0;
                                state_reg <= S_EMIT_RD;
                            end
                            else
                            begin
                                pass_reg  <= pass_reg + 4'd1;
                                state_reg <= S_PASS_RD;
                            end
                        end
                        else
                        begin
                            div_c_reg <= div_c_reg + 2'd1;
                            state_reg <= S_PASS_END;
                        end
                    end
                end
                S_EMIT_RD:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    ovalid_reg <= 1'b1;
                    oidx_reg   <= a_rdata;
                    olast_reg  <= (i_reg == n_reg - NW'(1));
                    if (i_reg == n_reg - NW'(1))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + NW'(1);
                        rd_i_reg  <= rd_i_reg + NW'(1);
                        state_reg <= S_EMIT_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end
endmodule

// File: design/kmeans_1d_three_clusters.sv
`timescale 1ns / 1ps
// After the closing request, the block ranks the samples when there are three or
// more, then runs each pass with its three divisions, then sends the results.
// Throughput: one sample per cycle while loading; one batch at a time, as
// samples are taken only while the core is in its load state.
// Reset (rst_n, asynchronous, active low) empties the batch, clears the
// centroids, sums and counts, and sets pass_count to ten.
`include "kmeans_1d_three_clusters_assert.svh"
module kmeans_1d_three_clusters
    import km1d_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Sample requests: tdata holds sample; tlast marks the end of a batch.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                   s_axis_tlast,
    // Result requests: tdata holds cluster_index in bits 1:0, zero above.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,
    output logic                   m_axis_tlast,
    // Configuration: pass_count in cfg_data.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [3:0]             cfg_data
);
    logic [3:0] pass_reg;
    logic [3:0] passes;
    logic [1:0] idx;
    logic       busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= DefaultPasses;
        end
        else if (cfg_valid)
        begin
            pass_reg <= cfg_data;
        end
    end

    // A pass count of zero runs one pass.
    assign passes = (pass_reg == 4'd0) ? 4'd1 : pass_reg;

    km1d_core #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_core (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_sample(s_axis_tdata[SAMPLE_BITS-1:0]), .in_last(s_axis_tlast),
        .passes(passes),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_index(idx), .out_last(m_axis_tlast), .busy(busy));

    assign m_axis_tdata = {6'b0, idx};

    `KM_ASSERT_IMPL(a_idx_range, clk, rst_n, m_axis_tvalid, idx != 2'd3)
    `KM_ASSERT_IMPL(a_no_load_out, clk, rst_n, s_axis_tready && !busy, !m_axis_tvalid)
    `KM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))
endmodule
